// File: rtl/brt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_pkg: shared types and constants of the best route table
// Request and response payloads, the token that walks the cell chain and
// the request type codes.
// ----------------------------------------------------------------------------
package brt_pkg;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic signed [15:0] C_HEALTH_FLOOR = -16'sd10000;

    typedef struct packed {
        logic                req_type;
        logic [31:0]         req_gateway;
        logic [31:0]         req_node;
        logic [63:0]         req_timestamp;
        logic signed [15:0]  req_health;
    } t_req;

    typedef struct packed {
        logic                path_found;
        logic [31:0]         best_gateway;
        logic [31:0]         best_node;
        logic [63:0]         best_timestamp;
        logic signed [15:0]  best_health;
        logic                insert_dropped;
    } t_rsp;

    typedef struct packed {
        logic                active;
        logic                req_type;
        logic [31:0]         gateway;
        logic [31:0]         node;
        logic [63:0]         timestamp;
        logic signed [15:0]  health;
        logic                done;
        logic                found;
        logic [31:0]         best_gateway;
        logic [31:0]         best_node;
        logic [63:0]         best_timestamp;
        logic signed [15:0]  best_health;
    } t_token;

endpackage

// File: rtl/brt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_req_if / brt_rsp_if: valid/ready channels of the best route table
// One interface carries requests in, the other carries responses out.
// ----------------------------------------------------------------------------
interface brt_req_if;
    logic         valid;
    logic         ready;
    brt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brt_rsp_if;
    logic         valid;
    logic         ready;
    brt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/best_route_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_route_table: route table with best path lookup
// A chain of slot cells that a request token walks one cell per cycle while the chain is not frozen.
// ----------------------------------------------------------------------------
//  Channel   Direction  Modport  Payload
//  i_req     in         sink     type, gateway, node, timestamp, health
//  o_rsp     out        source   found, best path fields, insert dropped
//
// After a request is accepted the input stays closed until its token leaves
// the last cell; the response is registered and the input reopens together.
// One request is in the chain at a time.
// Reset empties the table at once; no clearing pass is needed.
// A response still waiting when the next request reaches the end of the
// chain freezes the whole chain until it is taken.
// ----------------------------------------------------------------------------
module best_route_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brt_req_if.sink   i_req,
    brt_rsp_if.source o_rsp
);

    brt_pkg::t_token w_tok [0:TABLE_DEPTH];
    brt_pkg::t_token w_last;
    brt_pkg::t_rsp   r_rsp;
    brt_pkg::t_rsp   n_rsp;
    logic            r_rsp_valid;
    logic            r_busy;
    logic            w_accept;
    logic            w_en;
    logic            w_load;
    logic            w_hit_out;

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_tok[0]                = '0;
        w_tok[0].active         = w_accept;
        w_tok[0].req_type       = i_req.data.req_type;
        w_tok[0].gateway        = i_req.data.req_gateway;
        w_tok[0].node           = i_req.data.req_node;
        w_tok[0].timestamp      = i_req.data.req_timestamp;
        w_tok[0].health         = i_req.data.req_health;
        w_tok[0].best_health    = brt_pkg::C_HEALTH_FLOOR;
    end

    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            brt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign w_last = w_tok[TABLE_DEPTH];
    assign w_en   = !(w_last.active && r_rsp_valid && !o_rsp.ready);
    assign w_load = w_last.active && w_en;

    assign w_hit_out = (w_last.req_type == brt_pkg::REQ_LOOKUP) && w_last.found;

    always_comb begin
        n_rsp                = '0;
        n_rsp.path_found     = w_hit_out;
        n_rsp.insert_dropped = (w_last.req_type == brt_pkg::REQ_UPDATE) && !w_last.done;
        if (w_hit_out) begin
            n_rsp.best_gateway   = w_last.best_gateway;
            n_rsp.best_node      = w_last.best_node;
            n_rsp.best_timestamp = w_last.best_timestamp;
            n_rsp.best_health    = w_last.best_health;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

// File: rtl/brt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_cell: one route table slot
// Holds one path and passes the request token on to its neighbor, updating,
// inserting or competing for the best lookup result on the way.
// ----------------------------------------------------------------------------
module brt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  brt_pkg::t_token i_tok,
    output brt_pkg::t_token o_tok
);

    logic               r_valid;
    logic [31:0]        r_gateway;
    logic [31:0]        r_node;
    logic [63:0]        r_timestamp;
    logic signed [15:0] r_health;
    brt_pkg::t_token    r_tok;
    brt_pkg::t_token    n_tok;

    logic w_match_node;
    logic w_hit;
    logic w_ins;
    logic w_better;

    assign w_match_node = r_valid && (r_node == i_tok.node);
    assign w_hit = i_tok.active && (i_tok.req_type == brt_pkg::REQ_UPDATE)
                   && w_match_node && (r_gateway == i_tok.gateway);
    assign w_ins = i_tok.active && (i_tok.req_type == brt_pkg::REQ_UPDATE)
                   && !r_valid && !i_tok.done;
    assign w_better = i_tok.active && (i_tok.req_type == brt_pkg::REQ_LOOKUP)
                      && w_match_node && (r_health >= i_tok.best_health);

    always_comb begin
        n_tok      = i_tok;
        n_tok.done = i_tok.done | w_hit | w_ins;
        if (w_better) begin
            n_tok.found          = 1'b1;
            n_tok.best_gateway   = r_gateway;
            n_tok.best_node      = r_node;
            n_tok.best_timestamp = r_timestamp;
            n_tok.best_health    = r_health;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (w_ins) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && (w_hit || w_ins)) begin
            r_timestamp <= i_tok.timestamp;
            r_health    <= i_tok.health;
        end
        if (i_en && w_ins) begin
            r_gateway <= i_tok.gateway;
            r_node    <= i_tok.node;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/brt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_checker: port level checks of the best route table
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module brt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input brt_pkg::t_rsp i_rsp_data
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("Stalled response changed or dropped.");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("A second request was accepted while one is in flight.");

    a_found_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.path_found |-> !i_rsp_data.insert_dropped)
        else $error("Lookup response flags a dropped insert.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.path_found |->
            i_rsp_data.best_health == 16'sd0 && i_rsp_data.best_node == 32'd0
            && i_rsp_data.best_gateway == 32'd0 && i_rsp_data.best_timestamp == 64'd0)
        else $error("Response without a path carries nonzero path fields.");

    a_found_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.path_found |->
            i_rsp_data.best_health >= brt_pkg::C_HEALTH_FLOOR)
        else $error("Returned path is below the health floor.");

endmodule

bind best_route_table brt_checker u_brt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the best route table
// Sends update and lookup requests through the request channel and checks
// every response against a route table kept inside the testbench. A short
// directed sequence covers empty lookups, health ties, the health floor and
// all-zero and all-one addresses. A random sequence then fills the table
// until inserts are dropped, with random idling on both channels, a long
// response stall and a pause that lets the table drain.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_REQS  = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = TABLE_DEPTH + 16;
    localparam int STALL_AT     = 300;
    localparam int STALL_CYCLES = 400;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 720;

    logic i_clk;
    logic i_rst_n;

    brt_req_if req_if ();
    brt_rsp_if rsp_if ();

    best_route_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    logic                   tbl_valid     [TABLE_DEPTH];
    logic [31:0]            tbl_gateway   [TABLE_DEPTH];
    logic [31:0]            tbl_node      [TABLE_DEPTH];
    logic [63:0]            tbl_timestamp [TABLE_DEPTH];
    logic signed [15:0]     tbl_health    [TABLE_DEPTH];
    int                     tbl_count;

    brt_pkg::t_req  req_backlog [$];
    brt_pkg::t_rsp  route_rsp_due [$];
    int    reqs_queued;
    int    reqs_issued;
    int    fail_count;
    int    cycle_count;
    logic  req_taken;
    int    hold_left;
    logic  hold_done;
    logic [31:0] node_pool [8];
    logic [31:0] gw_pool   [8];

    function automatic logic quiet_phase();
        return reqs_issued >= QUIET_FROM && reqs_issued < QUIET_TO;
    endfunction

    task automatic predict_route_rsp(input brt_pkg::t_req r, output brt_pkg::t_rsp res);
        logic               hit;
        logic               found;
        logic signed [15:0] best_h;
        int                 best_i;
        res = '0;
        if (r.req_type == brt_pkg::REQ_UPDATE) begin
            hit = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_valid[i] && tbl_node[i] == r.req_node
                        && tbl_gateway[i] == r.req_gateway) begin
                    hit = 1'b1;
                    tbl_timestamp[i] = r.req_timestamp;
                    tbl_health[i] = r.req_health;
                end
            end
            if (!hit) begin
                if (tbl_count < TABLE_DEPTH) begin
                    tbl_valid[tbl_count]     = 1'b1;
                    tbl_gateway[tbl_count]   = r.req_gateway;
                    tbl_node[tbl_count]      = r.req_node;
                    tbl_timestamp[tbl_count] = r.req_timestamp;
                    tbl_health[tbl_count]    = r.req_health;
                    tbl_count++;
                end else begin
                    res.insert_dropped = 1'b1;
                end
            end
        end else begin
            found  = 1'b0;
            best_h = brt_pkg::C_HEALTH_FLOOR;
            best_i = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_valid[i] && tbl_node[i] == r.req_node
                        && tbl_health[i] >= best_h) begin
                    best_h = tbl_health[i];
                    best_i = i;
                    found  = 1'b1;
                end
            end
            if (found) begin
                res.path_found     = 1'b1;
                res.best_gateway   = tbl_gateway[best_i];
                res.best_node      = tbl_node[best_i];
                res.best_timestamp = tbl_timestamp[best_i];
                res.best_health    = tbl_health[best_i];
            end
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_req(input logic kind, input logic [31:0] gw,
                             input logic [31:0] node, input logic [63:0] stamp,
                             input logic signed [15:0] health);
        brt_pkg::t_req r;
        r.req_type      = kind;
        r.req_gateway   = gw;
        r.req_node      = node;
        r.req_timestamp = stamp;
        r.req_health    = health;
        req_backlog = {req_backlog, r};
        reqs_queued++;
    endtask

    function automatic logic signed [15:0] pick_health();
        case ($urandom_range(0, 9))
            0: return brt_pkg::C_HEALTH_FLOOR;
            1: return brt_pkg::C_HEALTH_FLOOR - 16'sd1;
            2: return -16'sd32768;
            3: return 16'sd32767;
            4, 5: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_stamp();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_random_req();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            queue_req(brt_pkg::REQ_UPDATE, gw_pool[$urandom_range(0, 7)],
                      node_pool[$urandom_range(0, 7)], pick_stamp(), pick_health());
        end else if (pick < 85) begin
            queue_req(brt_pkg::REQ_LOOKUP, $urandom, node_pool[$urandom_range(0, 7)],
                      pick_stamp(), 16'($urandom));
        end else begin
            queue_req(1'($urandom), $urandom, $urandom, pick_stamp(), pick_health());
        end
    endtask

    task automatic wait_drain();
        while (reqs_issued != reqs_queued || route_rsp_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        brt_pkg::t_rsp due;
        req_taken = i_rst_n && req_if.valid && req_if.ready;
        if (req_taken) begin
            predict_route_rsp(req_if.data, due);
            route_rsp_due = {route_rsp_due, due};
            reqs_issued++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (req_backlog.size() != 0 && (quiet_phase() || $urandom_range(0, 99) >= 10)) begin
                req_if.data  <= req_backlog.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // The long stall freezes the table while the next request waits at the input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && reqs_issued >= STALL_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= STALL_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= quiet_phase() || $urandom_range(0, 99) >= 10;
        end
    end

    always @(posedge i_clk) begin
        brt_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (route_rsp_due.size() == 0) begin
                $error("response arrived with no request outstanding");
                fail_count++;
            end else begin
                want = route_rsp_due.pop_front();
                check_field("path_found", 64'(want.path_found), 64'(rsp_if.data.path_found));
                check_field("best_gateway", 64'(want.best_gateway),
                            64'(rsp_if.data.best_gateway));
                check_field("best_node", 64'(want.best_node), 64'(rsp_if.data.best_node));
                check_field("best_timestamp", want.best_timestamp,
                            rsp_if.data.best_timestamp);
                check_field("best_health", 64'(want.best_health),
                            64'(rsp_if.data.best_health));
                check_field("insert_dropped", 64'(want.insert_dropped),
                            64'(rsp_if.data.insert_dropped));
            end
        end
    end

    initial begin
        logic [31:0] node_a;
        logic [31:0] node_b;
        logic [31:0] gw_a;
        logic [31:0] gw_b;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        req_taken    = 1'b0;
        reqs_queued  = 0;
        reqs_issued  = 0;
        fail_count   = 0;
        cycle_count  = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        tbl_count    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i]     = 1'b0;
            tbl_gateway[i]   = '0;
            tbl_node[i]      = '0;
            tbl_timestamp[i] = '0;
            tbl_health[i]    = '0;
        end
        node_pool[0] = '0;
        node_pool[1] = '1;
        gw_pool[0]   = '0;
        gw_pool[1]   = '1;
        for (int i = 2; i < 8; i++) begin
            node_pool[i] = $urandom;
            gw_pool[i]   = $urandom;
        end
        node_a = node_pool[2];
        node_b = node_pool[3];
        gw_a   = gw_pool[2];
        gw_b   = gw_pool[3];

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed sequence: empty table, ties, health floor, extreme addresses.
        queue_req(brt_pkg::REQ_LOOKUP, '0, node_a, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, gw_a, node_a, '1, 16'sd32767);
        queue_req(brt_pkg::REQ_LOOKUP, '1, node_a, '1, -16'sd1);
        queue_req(brt_pkg::REQ_UPDATE, gw_b, node_a, '0, 16'sd32767);
        queue_req(brt_pkg::REQ_LOOKUP, '0, node_a, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, gw_a, node_a, 64'h8000_0000_0000_0000,
                  brt_pkg::C_HEALTH_FLOOR);
        queue_req(brt_pkg::REQ_UPDATE, gw_b, node_a, 64'd1,
                  brt_pkg::C_HEALTH_FLOOR - 16'sd1);
        queue_req(brt_pkg::REQ_LOOKUP, '0, node_a, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, gw_a, node_a, 64'd2, -16'sd32768);
        queue_req(brt_pkg::REQ_LOOKUP, '0, node_a, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, '0, '0, '0, '0);
        queue_req(brt_pkg::REQ_LOOKUP, '0, '0, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, '1, '1, '1, -16'sd1);
        queue_req(brt_pkg::REQ_UPDATE, '0, '1, 64'd3, -16'sd1);
        queue_req(brt_pkg::REQ_LOOKUP, '0, '1, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, '1, '0, 64'd4, 16'sd100);
        queue_req(brt_pkg::REQ_LOOKUP, '1, '0, '1, 16'sd32767);
        queue_req(brt_pkg::REQ_LOOKUP, '0, node_b, '0, '0);
        queue_req(brt_pkg::REQ_UPDATE, gw_a, node_b, 64'd5, 16'sd1);
        queue_req(brt_pkg::REQ_LOOKUP, '0, node_b, '0, '0);
        wait_drain();

        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (k == RANDOM_REQS / 2) begin
                wait_drain();
            end
            queue_random_req();
        end
        wait_drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (fail_count == 0 && route_rsp_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
